@@ design/chfd_pkg.sv @@
package chfd_pkg;

    // byte and word widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned RAW_W  = 16;

    // crc-8 over each two-byte word
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

    // scaling constants, full scale raw value is 65535
    localparam int unsigned TEMP_SPAN_W = 11;
    localparam int unsigned HUMI_SPAN_W = 10;
    localparam logic [TEMP_SPAN_W-1:0] TEMP_SPAN = 11'd1750;
    localparam logic [HUMI_SPAN_W-1:0] HUMI_SPAN = 10'd1000;
    localparam int unsigned TEMP_PROD_W = RAW_W + TEMP_SPAN_W;
    localparam int unsigned HUMI_PROD_W = RAW_W + HUMI_SPAN_W;
    localparam logic [RAW_W:0] RAW_FULL = 17'd65535;

    // result field widths
    localparam int unsigned TEMP_W = 12;
    localparam int unsigned HUMI_W = 10;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 12'd450;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd450;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd1300;
    localparam logic [HUMI_W-1:0] HUMI_MAX = 10'd1000;

    // stream payload widths
    localparam int unsigned OUT_DATA_W = 24;

    // raw words of one complete frame
    typedef struct packed {
        logic             bad;
        logic [RAW_W-1:0] temp_raw;
        logic [RAW_W-1:0] humi_raw;
    } t_raw;

    // one byte of crc-8, msb first, no reflection
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/chfd_frame.sv @@
module chfd_frame (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_byte_vld,
    output logic                        o_byte_rdy,
    input  logic [chfd_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_start,
    output logic                        o_raw_vld,
    input  logic                        i_raw_rdy,
    output chfd_pkg::t_raw              o_raw
);
    import chfd_pkg::*;

    // byte position codes
    localparam logic [2:0] POS_TEMP_HI = 3'd0;
    localparam logic [2:0] POS_TEMP_LO = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUMI_HI = 3'd3;
    localparam logic [2:0] POS_HUMI_LO = 3'd4;
    localparam logic [2:0] POS_HUMI_CRC = 3'd5;

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;

    logic [2:0]        r_pos, n_pos;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [RAW_W-1:0]  r_temp_raw, n_temp_raw;
    logic [BYTE_W-1:0] r_humi_hi, n_humi_hi;
    logic [BYTE_W-1:0] r_humi_lo, n_humi_lo;
    logic              r_temp_bad, n_temp_bad;

    logic              r_raw_vld;
    t_raw              r_raw, n_raw;

    logic [2:0]        pos;
    logic              is_last;
    logic              in_adv;

    // a frame mark always restarts at the first byte
    assign pos     = r_in_start ? POS_TEMP_HI : r_pos;
    assign is_last = (pos == POS_HUMI_CRC);
    assign in_adv  = r_in_vld && (!is_last || !r_raw_vld || i_raw_rdy);

    assign o_byte_rdy = !r_in_vld || in_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_byte_rdy) begin
            r_in_vld <= i_byte_vld;
        end
        if (o_byte_rdy && i_byte_vld) begin
            r_in_byte  <= i_byte;
            r_in_start <= i_start;
        end
    end

    // frame position, crc and raw word collection
    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_temp_raw = r_temp_raw;
        n_humi_hi  = r_humi_hi;
        n_humi_lo  = r_humi_lo;
        n_temp_bad = r_temp_bad;
        n_raw.bad      = r_temp_bad || (r_in_byte != r_crc);
        n_raw.temp_raw = r_temp_raw;
        n_raw.humi_raw = {r_humi_hi, r_humi_lo};
        case (pos)
            POS_TEMP_LO: begin
                n_crc      = crc8_byte(r_crc, r_in_byte);
                n_temp_raw = {r_temp_raw[RAW_W-1:BYTE_W], r_in_byte};
                n_pos      = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
                n_temp_bad = (r_in_byte != r_crc);
                n_crc      = CRC_INIT;
                n_pos      = POS_HUMI_HI;
            end
            POS_HUMI_HI: begin
                n_crc     = crc8_byte(CRC_INIT, r_in_byte);
                n_humi_hi = r_in_byte;
                n_pos     = POS_HUMI_LO;
            end
            POS_HUMI_LO: begin
                n_crc     = crc8_byte(r_crc, r_in_byte);
                n_humi_lo = r_in_byte;
                n_pos     = POS_HUMI_CRC;
            end
            POS_HUMI_CRC: begin
                n_crc = CRC_INIT;
                n_pos = POS_TEMP_HI;
            end
            default: begin
                // first byte, and any position that cannot arise
                n_crc      = crc8_byte(CRC_INIT, r_in_byte);
                n_temp_raw = {r_in_byte, {BYTE_W{1'b0}}};
                n_pos      = POS_TEMP_LO;
            end
        endcase
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_TEMP_HI;
            r_crc      <= CRC_INIT;
            r_temp_raw <= '0;
            r_humi_hi  <= '0;
            r_humi_lo  <= '0;
            r_temp_bad <= 1'b0;
        end else if (in_adv) begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_temp_raw <= n_temp_raw;
            r_humi_hi  <= n_humi_hi;
            r_humi_lo  <= n_humi_lo;
            r_temp_bad <= n_temp_bad;
        end
    end

    // completed frame register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_vld <= 1'b0;
        end else if (in_adv && is_last) begin
            r_raw_vld <= 1'b1;
        end else if (i_raw_rdy) begin
            r_raw_vld <= 1'b0;
        end
        if (in_adv && is_last) begin
            r_raw <= n_raw;
        end
    end

    assign o_raw_vld = r_raw_vld;
    assign o_raw     = r_raw;

endmodule

@@ design/chfd_scale.sv @@
module chfd_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_raw_vld,
    output logic                            o_raw_rdy,
    input  chfd_pkg::t_raw                  i_raw,
    output logic                            o_res_vld,
    input  logic                            i_res_rdy,
    output logic [chfd_pkg::TEMP_W-1:0]     o_temp,
    output logic [chfd_pkg::HUMI_W-1:0]     o_humi,
    output logic                            o_status
);
    import chfd_pkg::*;

    localparam int unsigned TEMP_Q_W = TEMP_PROD_W - RAW_W;
    localparam int unsigned HUMI_Q_W = HUMI_PROD_W - RAW_W;

    logic                   r_prod_vld;
    logic                   r_prod_bad;
    logic [TEMP_PROD_W-1:0] r_prod_temp;
    logic [HUMI_PROD_W-1:0] r_prod_humi;

    logic                   r_res_vld;
    logic [TEMP_W-1:0]      r_res_temp;
    logic [HUMI_W-1:0]      r_res_humi;
    logic                   r_res_status;

    logic                   res_free;
    logic                   prod_free;

    logic [TEMP_Q_W-1:0]    temp_q0;
    logic [RAW_W:0]         temp_rem;
    logic [TEMP_Q_W-1:0]    temp_q;
    logic [HUMI_Q_W-1:0]    humi_q0;
    logic [RAW_W:0]         humi_rem;
    logic [HUMI_Q_W-1:0]    humi_q;
    logic [TEMP_W-1:0]      temp_val;

    assign res_free  = !r_res_vld || i_res_rdy;
    assign prod_free = !r_prod_vld || res_free;
    assign o_raw_rdy = prod_free;

    // span multiplication
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (prod_free) begin
            r_prod_vld <= i_raw_vld;
        end
        if (prod_free && i_raw_vld) begin
            r_prod_bad  <= i_raw.bad;
            r_prod_temp <= TEMP_PROD_W'(TEMP_SPAN) * TEMP_PROD_W'(i_raw.temp_raw);
            r_prod_humi <= HUMI_PROD_W'(HUMI_SPAN) * HUMI_PROD_W'(i_raw.humi_raw);
        end
    end

    // divide by 65535: x = 65536*q0 + r gives remainder r + q0, one correction step
    always_comb begin
        temp_q0  = r_prod_temp[TEMP_PROD_W-1:RAW_W];
        temp_rem = {1'b0, r_prod_temp[RAW_W-1:0]} + (RAW_W+1)'(temp_q0);
        temp_q   = (temp_rem >= RAW_FULL) ? temp_q0 + 1'b1 : temp_q0;
        humi_q0  = r_prod_humi[HUMI_PROD_W-1:RAW_W];
        humi_rem = {1'b0, r_prod_humi[RAW_W-1:0]} + (RAW_W+1)'(humi_q0);
        humi_q   = (humi_rem >= RAW_FULL) ? humi_q0 + 1'b1 : humi_q0;
        temp_val = TEMP_W'(temp_q) - TEMP_OFFSET;
    end

    // result register, values forced to zero on a checksum error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (res_free) begin
            r_res_vld <= r_prod_vld;
        end
        if (res_free && r_prod_vld) begin
            r_res_status <= r_prod_bad;
            r_res_temp   <= r_prod_bad ? '0 : temp_val;
            r_res_humi   <= r_prod_bad ? '0 : HUMI_W'(humi_q);
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_temp    = r_res_temp;
    assign o_humi    = r_res_humi;
    assign o_status  = r_res_status;

endmodule

@@ design/crc_checked_humidity_frame_decoder_core.sv @@
// path: after its sixth byte is accepted, the result of a frame reaches the master side via
//   the input register, frame register, multiply register and result register, in that order
// throughput: one byte per cycle unless stalled; span multiply and divide are fully pipelined
// reset: synchronous active-low i_rst_n empties every stage and returns the frame
//   position to the first byte with the crc preset to 0xff
module crc_checked_humidity_frame_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // data_byte
    input  logic [chfd_pkg::BYTE_W-1:0]         i_s_axis_tdata,
    // frame_start
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // temperature_deci_c [11:0], humidity_deci_pct [21:12], zero pad [23:22]
    output logic [chfd_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // status
    output logic                                o_m_axis_tuser
);
    import chfd_pkg::*;

    logic              raw_vld;
    logic              raw_rdy;
    t_raw              raw;
    logic [TEMP_W-1:0] temp;
    logic [HUMI_W-1:0] humi;

    // byte parsing and crc check
    chfd_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (i_s_axis_tvalid),
        .o_byte_rdy (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_start    (i_s_axis_tuser),
        .o_raw_vld  (raw_vld),
        .i_raw_rdy  (raw_rdy),
        .o_raw      (raw)
    );

    // conversion to engineering units
    chfd_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raw_vld (raw_vld),
        .o_raw_rdy (raw_rdy),
        .i_raw     (raw),
        .o_res_vld (o_m_axis_tvalid),
        .i_res_rdy (i_m_axis_tready),
        .o_temp    (temp),
        .o_humi    (humi),
        .o_status  (o_m_axis_tuser)
    );

    // output beat packing
    assign o_m_axis_tdata = {{(OUT_DATA_W - TEMP_W - HUMI_W){1'b0}}, humi, temp};

    // checksum error beats carry zero values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> temp == '0 && humi == '0)
        else $error("checksum error beat with nonzero values");

    // good beats stay within the sensor range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            $signed(temp) >= TEMP_MIN && $signed(temp) <= TEMP_MAX && humi <= HUMI_MAX)
        else $error("converted value out of range");

    // a completed frame waiting on the scaler is held intact
    a_raw_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        raw_vld && !raw_rdy |=> raw_vld && $stable(raw))
        else $error("completed frame lost while stalled");

endmodule
